/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console character writer: the input
// and result words, action codes, control characters and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Cell layout: attribute byte high, character byte low
  localparam int unsigned CellW = 16;
  localparam int unsigned AttrW = 8;
  localparam int unsigned CharW = 8;

  // Fixed field widths of the result word
  localparam int unsigned RowOutW = 5;
  localparam int unsigned ColOutW = 7;
  localparam int unsigned PosOutW = 11;

  // Configuration register map
  localparam logic [1:0]       RegTextAttr   = 2'd0;
  localparam logic [AttrW-1:0] AttrResetVal  = 8'h07;

  // Control characters
  localparam logic [CharW-1:0] CharNewline   = 8'h0A;
  localparam logic [CharW-1:0] CharBackspace = 8'h08;
  localparam logic [CharW-1:0] CharSpace     = 8'h20;

  typedef enum logic [1:0] {
    ActPut   = 2'd0,
    ActClear = 2'd1,
    ActRead  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqExec,
    SeqReadWait,
    SeqScroll,
    SeqClear
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [RowOutW-1:0] cursor_row_out;
    logic [ColOutW-1:0] cursor_col_out;
    logic [PosOutW-1:0] cursor_position;
    logic [CellW-1:0]   cell_data;
    logic               scrolled;
  } tcw_out_t;

endpackage

`default_nettype wire

/* hw/rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/tcw_regs.sv */
// ----------------------------------------------------------------------------
// tcw_regs
// APB-style configuration port holding the text attribute register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [1:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic [tcw_pkg::AttrW-1:0]  attr_o
);

  import tcw_pkg::*;

  logic [AttrW-1:0] attr_q, attr_d;
  logic             wr_en;

  // Decode the access phase of a write
  assign wr_en = psel && penable && pwrite && (paddr == RegTextAttr);

  always_comb begin
    attr_d = attr_q;
    if (wr_en) begin
      attr_d = pwdata[AttrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= AttrResetVal;
    end else begin
      attr_q <= attr_d;
    end
  end

  // Read back, zero outside the map
  always_comb begin
    prdata = '0;
    if (paddr == RegTextAttr) begin
      prdata = {{(32 - AttrW){1'b0}}, attr_q};
    end
  end

  assign pready = 1'b1;
  assign attr_o = attr_q;

endmodule

`default_nettype wire

/* hw/rtl/tcw_seq.sv */
// ----------------------------------------------------------------------------
// tcw_seq
// Cursor state and action sequencer. Executes one word at a time against
// the cell RAM: single writes for put and backspace, a registered read for
// cell reads, and full sweeps for scroll (copy up, blank bottom) and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_seq #(
  parameter  int unsigned COLUMNS = 80,
  parameter  int unsigned ROWS    = 25,
  localparam int unsigned AddrW   = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [tcw_pkg::AttrW-1:0] attr_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tcw_pkg::tcw_in_t          in_word_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output tcw_pkg::tcw_out_t              out_word_o,
  output logic                           mem_we_o,
  output logic [AddrW-1:0]               mem_waddr_o,
  output logic [tcw_pkg::CellW-1:0]      mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AddrW-1:0]               mem_raddr_o,
  input  wire logic [tcw_pkg::CellW-1:0] mem_rdata_i
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned RowW      = $clog2(ROWS);

  localparam logic [AddrW-1:0] LastCell   = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] ScrollBase = AddrW'((ROWS - 1) * COLUMNS);
  localparam logic [AddrW-1:0] ScrollLast = AddrW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AddrW-1:0] RowStep    = AddrW'(COLUMNS);
  localparam logic [ColW-1:0]  LastCol    = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]  LastRow    = RowW'(ROWS - 1);

  seq_state_e       state_q, state_d;
  tcw_in_t          item_q, item_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] idx_q, idx_d;
  tcw_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_ready;
  logic             accept;
  logic             is_newline;
  logic             is_backspace;
  logic             scroll_needed;
  logic             addr_ok;
  logic             sweep_last;
  logic             finish;
  logic [CellW-1:0] blank;

  assign in_ready     = (state_q == SeqIdle) && (!out_valid_q || out_ready_i);
  assign accept       = in_valid_i && in_ready;
  assign is_newline   = (item_q.char_code == CharNewline);
  assign is_backspace = (item_q.char_code == CharBackspace);
  assign addr_ok      = (32'(item_q.cell_address) < CellCount);
  assign sweep_last   = (idx_q == LastCell);
  assign blank        = {attr_i, CharSpace};

  // A put pushes the cursor past the last row
  assign scroll_needed = (row_q == LastRow) &&
                         (is_newline || (!is_backspace && (col_q == LastCol)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SeqIdle: begin
        if (accept) begin
          state_d = SeqExec;
        end
      end
      SeqExec: begin
        case (item_q.action)
          ActPut:   state_d = scroll_needed ? SeqScroll : SeqIdle;
          ActClear: state_d = SeqClear;
          ActRead:  state_d = addr_ok ? SeqReadWait : SeqIdle;
          default:  state_d = SeqIdle;
        endcase
      end
      SeqReadWait: state_d = SeqIdle;
      SeqScroll, SeqClear: begin
        if (sweep_last) begin
          state_d = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  // Cursor update, RAM accesses and completion
  always_comb begin
    item_d      = accept ? in_word_i : item_q;
    row_d       = row_q;
    col_d       = col_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = blank;
    mem_re_o    = 1'b0;
    mem_raddr_o = AddrW'(item_q.cell_address);
    finish      = 1'b0;

    case (state_q)
      SeqExec: begin
        case (item_q.action)
          ActPut: begin
            if (is_newline) begin
              col_d = '0;
              if (!scroll_needed) begin
                row_d = row_q + RowW'(1);
                pos_d = pos_q + RowStep - AddrW'(col_q);
              end
            end else if (is_backspace) begin
              // Step back and blank, nothing at the origin
              if ((col_q != '0) || (row_q != '0)) begin
                pos_d       = pos_q - AddrW'(1);
                mem_we_o    = 1'b1;
                mem_waddr_o = pos_q - AddrW'(1);
                if (col_q != '0) begin
                  col_d = col_q - ColW'(1);
                end else begin
                  row_d = row_q - RowW'(1);
                  col_d = LastCol;
                end
              end
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pos_q;
              mem_wdata_o = {attr_i, item_q.char_code};
              if (col_q == LastCol) begin
                col_d = '0;
                if (!scroll_needed) begin
                  row_d = row_q + RowW'(1);
                  pos_d = pos_q + AddrW'(1);
                end
              end else begin
                col_d = col_q + ColW'(1);
                pos_d = pos_q + AddrW'(1);
              end
            end
            if (scroll_needed) begin
              // Land on the start of the bottom row, prime the first copy read
              row_d       = LastRow;
              pos_d       = ScrollBase;
              idx_d       = '0;
              mem_re_o    = 1'b1;
              mem_raddr_o = RowStep;
            end else begin
              finish = 1'b1;
            end
          end
          ActClear: begin
            row_d = '0;
            col_d = '0;
            pos_d = '0;
            idx_d = '0;
          end
          ActRead: begin
            if (addr_ok) begin
              mem_re_o = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      SeqReadWait: finish = 1'b1;
      SeqScroll: begin
        // Copy each cell up one row, then blank the bottom row
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = (idx_q < ScrollBase) ? mem_rdata_i : blank;
        mem_re_o    = (idx_q < ScrollLast);
        mem_raddr_o = idx_q + RowStep + AddrW'(1);
        idx_d       = idx_q + AddrW'(1);
        finish      = sweep_last;
      end
      SeqClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        idx_d       = idx_q + AddrW'(1);
        finish      = sweep_last;
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (finish) begin
      out_valid_d           = 1'b1;
      out_d.cursor_row_out  = RowOutW'(row_d);
      out_d.cursor_col_out  = ColOutW'(col_d);
      out_d.cursor_position = PosOutW'(pos_d);
      out_d.cell_data       = (state_q == SeqReadWait) ? mem_rdata_i : '0;
      out_d.scrolled        = (state_q == SeqScroll);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console over a COLUMNS x ROWS RAM of 16-bit cells with cursor,
// newline, backspace, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// One word is processed at a time. A cell read inside the screen goes
// through an extra wait state for the RAM's registered read. A clear, and
// any put that scrolls, sweeps all COLUMNS*ROWS cells (2000 at 80x25),
// since every cell goes through the RAM's single write port once. The
// result word carries the cursor after the word and is held in an output
// register; the next word is accepted only once that register is empty or
// is being emptied in the same cycle, so a stalled result stalls the input.
// Cell contents are undefined after reset until the first clear; no
// clearing pass runs at reset.
`default_nettype none

module text_console_char_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcw_pkg::tcw_in_t  in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tcw_pkg::tcw_out_t      out_word_o
);

  import tcw_pkg::*;

  localparam int unsigned CellCount = COLUMNS * ROWS;
  localparam int unsigned AddrW     = $clog2(CellCount);

  logic [AttrW-1:0] attr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [CellW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [CellW-1:0] mem_rdata;

  // Configuration registers
  tcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  // Cursor and action sequencer
  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Screen cell store
  tcw_ram #(
    .WIDTH (CellW),
    .DEPTH (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console character writer, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire tcw_pkg::tcw_out_t out_word_o
);

  import tcw_pkg::*;

  localparam logic [RowOutW-1:0] LastRowOut = RowOutW'(ROWS - 1);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // One word at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  // Cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_word_o.cursor_col_out) < COLUMNS) &&
                    (32'(out_word_o.cursor_row_out) < ROWS))
    else $error("cursor reported off screen");

  // A scroll leaves the cursor at the start of the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.scrolled |->
      (out_word_o.cursor_col_out == '0) && (out_word_o.cursor_row_out == LastRowOut))
    else $error("scroll result with cursor not at bottom row start");

endmodule

bind text_console_char_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

/* bench/tb_text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking bench for the text console character writer. A short
// directed table covers reset values, clear, control characters, wraps and
// scroll; random phases at several attribute settings follow. Every result
// word is checked against a fixed expectation or a cycle-free model of the screen and cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_char_writer;

  import tcw_pkg::*;

  localparam int Cols  = 80;
  localparam int Rows  = 25;
  localparam int Cells = Cols * Rows;

  // The package names only the three used actions
  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [1:0] AttrAddr  = 2'(4 * RegTextAttr);

  localparam int PhaseWords = 315;
  localparam int HoldCycles = 600;

  typedef struct {
    tcw_in_t  word;
    int       reps;
    bit       fixed;
    tcw_out_t want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [1:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  tcw_in_t     in_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  tcw_out_t    out_word_o;

  // Screen model: cell image, which cells hold defined content, cursor
  logic [15:0]  screen_img [Cells];
  bit           cell_set   [Cells];
  logic [4:0]   cur_r      = '0;
  logic [6:0]   cur_c      = '0;
  logic [7:0]   attr_q     = AttrResetVal;

  tcw_out_t     pending_results [$];
  int           mismatches   = 0;
  int           words_sent   = 0;
  int           results_seen = 0;
  int           reads_made   = 0;
  int           clears_made  = 0;
  int           scrolls_made = 0;
  int           attr_settings = 1;
  int           burst_left   = 0;
  int           hold_requests = 0;
  int           hold_served  = 0;
  int           hold_left    = 0;
  int           stall_cycle  = 0;
  int           stall_mode   = 0;

  text_console_char_writer #(
    .COLUMNS(Cols),
    .ROWS   (Rows)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic logic [15:0] blank_cell();
    return {attr_q, CharSpace};
  endfunction

  // Scroll one row when the cursor has run off the bottom
  function automatic bit scroll_past_bottom();
    if (cur_r < Rows) return 1'b0;
    for (int i = 0; i < Cells - Cols; i++) begin
      screen_img[i] = screen_img[i + Cols];
      cell_set[i]   = cell_set[i + Cols];
    end
    for (int i = Cells - Cols; i < Cells; i++) begin
      screen_img[i] = blank_cell();
      cell_set[i]   = 1'b1;
    end
    cur_r = 5'(Rows - 1);
    return 1'b1;
  endfunction

  // Apply one word to the screen model and produce its result word
  function automatic tcw_out_t console_apply(tcw_in_t w);
    tcw_out_t    r;
    logic [15:0] data;
    bit          scr;
    int          idx;
    data = '0;
    scr  = 1'b0;
    case (w.action)
      ActPut: begin
        if (w.char_code == CharNewline) begin
          cur_c = '0;
          cur_r = cur_r + 1;
          scr   = scroll_past_bottom();
        end else if (w.char_code == CharBackspace) begin
          // Step back, wrapping to the previous row; stay put at the origin
          if (cur_c != 0 || cur_r != 0) begin
            if (cur_c == 0) begin
              cur_r = cur_r - 1;
              cur_c = 7'(Cols - 1);
            end else begin
              cur_c = cur_c - 1;
            end
            idx = cur_r * Cols + cur_c;
            screen_img[idx] = blank_cell();
            cell_set[idx]   = 1'b1;
          end
        end else begin
          idx = cur_r * Cols + cur_c;
          screen_img[idx] = {attr_q, w.char_code};
          cell_set[idx]   = 1'b1;
          cur_c = cur_c + 1;
          if (cur_c >= Cols) begin
            cur_c = '0;
            cur_r = cur_r + 1;
          end
          scr = scroll_past_bottom();
        end
      end
      ActClear: begin
        for (int i = 0; i < Cells; i++) begin
          screen_img[i] = blank_cell();
          cell_set[i]   = 1'b1;
        end
        cur_r = '0;
        cur_c = '0;
        clears_made++;
      end
      ActRead: begin
        if (w.cell_address < Cells) data = screen_img[w.cell_address];
        reads_made++;
      end
      default: ;
    endcase
    if (scr) scrolls_made++;
    r.cursor_row_out  = cur_r;
    r.cursor_col_out  = cur_c;
    r.cursor_position = 11'(cur_r * Cols + cur_c);
    r.cell_data       = data;
    r.scrolled        = scr;
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus --

  function automatic tcw_out_t fixed_result(int row, int col, logic [15:0] data);
    tcw_out_t r;
    r.cursor_row_out  = 5'(row);
    r.cursor_col_out  = 7'(col);
    r.cursor_position = 11'(row * Cols + col);
    r.cell_data       = data;
    r.scrolled        = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] act, logic [7:0] ch, logic [10:0] addr,
                                       int reps, bit fixed, tcw_out_t want);
    dir_row_t d;
    d.word.action       = act;
    d.word.char_code    = ch;
    d.word.cell_address = addr;
    d.reps  = reps;
    d.fixed = fixed;
    d.want  = want;
    return d;
  endfunction

  // Pick a cell to read back; never one holding undefined content
  function automatic logic [10:0] pick_read_addr();
    int a;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 11'($urandom_range(Cells, 2047));
    if (roll < 50) begin
      a = cur_r * Cols + cur_c - $urandom_range(0, 3);
      if (a < 0) a = 0;
    end else begin
      a = $urandom_range(0, Cells - 1);
    end
    if (!cell_set[a]) return 11'($urandom_range(Cells, 2047));
    return 11'(a);
  endfunction

  function automatic tcw_in_t pick_word(bit text_only);
    tcw_in_t w;
    int      roll;
    w.action       = ActPut;
    w.char_code    = 8'($urandom_range(0, 255));
    w.cell_address = 11'($urandom_range(0, 2047));
    if (text_only) begin
      if (w.char_code == CharNewline || w.char_code == CharBackspace)
        w.char_code = 8'($urandom_range(8'h21, 8'h7E));
      return w;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
    end else if (roll < 57) begin
      w.char_code = CharNewline;
    end else if (roll < 61) begin
      w.char_code = CharBackspace;
    end else if (roll < 88) begin
      w.action       = ActRead;
      w.cell_address = pick_read_addr();
    end else if (roll < 90) begin
      w.action = ActClear;
    end else if (roll < 93) begin
      w.action = ActUnused;
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then pace the next one
  task automatic offer_word(tcw_in_t w, tcw_out_t want);
    int gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(want);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_modeled(tcw_in_t w);
    tcw_out_t want;
    want = console_apply(w);
    offer_word(w, want);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AttrAddr;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    attr_q = value;
    attr_settings++;
  endtask

  task automatic random_phase(int quota);
    int done_here;
    int run_len;
    done_here = 0;
    while (done_here < quota) begin
      if ($urandom_range(0, 49) == 0) begin
        // Long line of text, often enough to wrap and scroll at the bottom
        run_len = $urandom_range(40, 120);
        repeat (run_len) send_modeled(pick_word(1'b1));
        done_here += run_len;
      end else begin
        send_modeled(pick_word(1'b0));
        done_here++;
      end
    end
  endtask

  // ------------------------------------------------------------- receiver --

  // Stall on a changing pattern; serve a long hold-off when asked
  always @(posedge clk_i) begin
    stall_cycle++;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (stall_cycle % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Check each taken result word against the oldest expectation
  always @(posedge clk_i) begin
    tcw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: row %0d col %0d pos %0d data %h scr %0b",
                   $realtime, out_word_o.cursor_row_out, out_word_o.cursor_col_out,
                   out_word_o.cursor_position, out_word_o.cell_data, out_word_o.scrolled);
      end else begin
        want = pending_results.pop_front();
        if (out_word_o.cursor_row_out !== want.cursor_row_out ||
            out_word_o.cursor_col_out !== want.cursor_col_out ||
            out_word_o.cursor_position !== want.cursor_position ||
            out_word_o.cell_data !== want.cell_data ||
            out_word_o.scrolled !== want.scrolled) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result %0d mismatch: expected row %0d col %0d pos %0d ",
                      "data %h scr %0b, got row %0d col %0d pos %0d data %h scr %0b"},
                     $realtime, results_seen, want.cursor_row_out, want.cursor_col_out,
                     want.cursor_position, want.cell_data, want.scrolled,
                     out_word_o.cursor_row_out, out_word_o.cursor_col_out,
                     out_word_o.cursor_position, out_word_o.cell_data,
                     out_word_o.scrolled);
        end
      end
    end
  end

  // ----------------------------------------------------------------- main --

  initial begin
    dir_row_t    dir_tab [$];
    tcw_out_t    want;
    logic [7:0]  attr_plan [5];
    for (int i = 0; i < Cells; i++) begin
      screen_img[i] = '0;
      cell_set[i]   = 1'b0;
    end

    // Reset state, clear, control characters, wraps and a newline scroll
    dir_tab.push_back(dir_row(ActUnused, 8'hFF, 11'h7FF, 1, 1, fixed_result(0, 0, 16'h0)));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'h7FF, 1, 1, fixed_result(0, 0, 16'h0)));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd2000, 1, 1, fixed_result(0, 0, 16'h0)));
    dir_tab.push_back(dir_row(ActClear, 8'h00, 11'h000, 1, 1, fixed_result(0, 0, 16'h0)));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd0, 1, 1, fixed_result(0, 0, 16'h0720)));
    dir_tab.push_back(dir_row(ActRead, 8'hFF, 11'd1999, 1, 1, fixed_result(0, 0, 16'h0720)));
    dir_tab.push_back(dir_row(ActPut, CharBackspace, 11'h0, 1, 1, fixed_result(0, 0, 16'h0)));
    dir_tab.push_back(dir_row(ActPut, 8'h00, 11'h000, 1, 1, fixed_result(0, 1, 16'h0)));
    dir_tab.push_back(dir_row(ActPut, 8'hFF, 11'h7FF, 1, 1, fixed_result(0, 2, 16'h0)));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd0, 1, 1, fixed_result(0, 2, 16'h0700)));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd1, 1, 1, fixed_result(0, 2, 16'h07FF)));
    dir_tab.push_back(dir_row(ActPut, CharBackspace, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd1, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, CharNewline, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, CharBackspace, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd79, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, 8'h41, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd79, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, CharNewline, 11'h0, 23, 0, want));
    dir_tab.push_back(dir_row(ActPut, 8'h5A, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, CharNewline, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd1840, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd1920, 1, 0, want));
    dir_tab.push_back(dir_row(ActPut, CharBackspace, 11'h0, 1, 0, want));
    dir_tab.push_back(dir_row(ActRead, 8'h00, 11'd1919, 1, 0, want));

    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = 8'($urandom_range(1, 254));
    attr_plan[3] = 8'h1E;
    attr_plan[4] = 8'($urandom_range(0, 255));

    // Hold reset, then release on an edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[k]) begin
      for (int n = 0; n < dir_tab[k].reps; n++) begin
        want = console_apply(dir_tab[k].word);
        offer_word(dir_tab[k].word, dir_tab[k].fixed ? dir_tab[k].want : want);
      end
    end

    // Random phases, one per attribute setting; stall the output in one
    foreach (attr_plan[p]) begin
      drain_results();
      write_attribute(attr_plan[p]);
      if (p == 1) hold_requests++;
      random_phase(PhaseWords);
    end

    in_valid_i <= 1'b0;
    for (int spin = 0; spin < 50000 && pending_results.size() != 0; spin++)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Sent %0d words under %0d attribute settings: %0d reads, %0d clears, %0d scrolls.",
             words_sent, attr_settings, reads_made, clears_made, scrolls_made);
    $display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_regs.sv
hw/rtl/tcw_seq.sv
hw/rtl/text_console_char_writer.sv
hw/rtl/tcw_checker.sv
bench/tb_text_console_char_writer.sv
